@@ rtl/wpb_pkg.sv @@
// ----------------------------------------------------------------------------
// Waveform peak bar builder package
// Shared widths, register codes, configuration defaults and payload types.
// ----------------------------------------------------------------------------
package wpb_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int SPB_BITS       = 24;
  localparam int VH_BITS        = 12;
  localparam int PX_BITS        = 8;
  localparam int STEP_BITS      = 15;
  localparam int INDEX_BITS     = 24;
  localparam int X_BITS         = 33;
  localparam int Q4_BITS        = 16;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 24;

  localparam int BUCKET_DIVISOR = 720;

  localparam logic [Q4_BITS-1:0]  MIN_HEIGHT_Q4 = 16'd32;

  localparam logic [SPB_BITS-1:0]  SPB_RESET         = 24'd1;
  localparam logic [VH_BITS-1:0]   VIEW_HEIGHT_RESET = 12'd64;
  localparam logic [PX_BITS-1:0]   BAR_WIDTH_RESET   = 8'd1;
  localparam logic [PX_BITS-1:0]   BAR_SPACING_RESET = 8'd1;
  localparam logic [STEP_BITS-1:0] STEP_RESET        = 15'd1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SAMPLES_PER_BUCKET = 4'd0,
    REG_VIEW_HEIGHT        = 4'd1,
    REG_BAR_WIDTH          = 4'd2,
    REG_BAR_SPACING        = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [SPB_BITS-1:0]  spb;    // samples per bucket, zero read as one
    logic [STEP_BITS-1:0] step;   // max(1, samples per bucket / 720)
    logic [VH_BITS-1:0]   view_height;
    logic [PX_BITS-1:0]   bar_width;
    logic [PX_BITS-1:0]   bar_spacing;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } sample_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]  bar_index;
    logic [SAMPLE_BITS-1:0] peak;
  } pend_bar_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]     bar_index;
    logic [X_BITS-1:0]         bar_x;
    logic signed [Q4_BITS-1:0] bar_y;
    logic [PX_BITS-1:0]        bar_out_width;
    logic [Q4_BITS-1:0]        bar_height;
  } bar_item_t;

endpackage

@@ rtl/wpb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the four settings and derives the sampling step when the bucket size
// is written.
// ----------------------------------------------------------------------------
module wpb_cfg_regs
  import wpb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  // spb / 720 is (spb / 16) / 45; the 20-bit quotient of the shift is divided
  // by 45 through a reciprocal that is exact over the whole 20-bit range.
  localparam int DIV_LOW        = BUCKET_DIVISOR / 45;
  localparam int DIV_SHIFT_BITS = $clog2(DIV_LOW);
  localparam int Q_IN_BITS      = SPB_BITS - DIV_SHIFT_BITS;
  localparam int RECIP_SHIFT    = 26;
  localparam int RECIP_BITS     = 21;
  localparam logic [RECIP_BITS-1:0] DIV_RECIP =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) / 64'd45) + 64'd1);
  localparam int PROD_BITS      = Q_IN_BITS + RECIP_BITS;

  logic [SPB_BITS-1:0]  spb_new;
  logic [PROD_BITS-1:0] quot_prod;
  logic [STEP_BITS-1:0] quot;
  logic [STEP_BITS-1:0] step_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    spb_new   = cfg_data[SPB_BITS-1:0];
    quot_prod = PROD_BITS'(spb_new[SPB_BITS-1:DIV_SHIFT_BITS]) * PROD_BITS'(DIV_RECIP);
    quot      = quot_prod[RECIP_SHIFT +: STEP_BITS];
    step_next = (quot == '0) ? STEP_BITS'(1) : quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spb         <= SPB_RESET;
      cfg.step        <= STEP_RESET;
      cfg.view_height <= VIEW_HEIGHT_RESET;
      cfg.bar_width   <= BAR_WIDTH_RESET;
      cfg.bar_spacing <= BAR_SPACING_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLES_PER_BUCKET: begin
          cfg.spb  <= (spb_new == '0) ? SPB_BITS'(1) : spb_new;
          cfg.step <= step_next;
        end
        REG_VIEW_HEIGHT: cfg.view_height <= cfg_data[VH_BITS-1:0];
        REG_BAR_WIDTH:   cfg.bar_width   <= cfg_data[PX_BITS-1:0];
        REG_BAR_SPACING: cfg.bar_spacing <= cfg_data[PX_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/wpb_bucket.sv @@
// ----------------------------------------------------------------------------
// Bucket tracker
// Registers each sample, tracks the strided peak of the current bucket and
// hands a finished bucket to the bar stage.
// ----------------------------------------------------------------------------
module wpb_bucket
  import wpb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         smp_valid,
  output logic         smp_ready,
  input  sample_item_t smp,
  output logic         pend_valid,
  input  logic         pend_take,
  output pend_bar_t    pend
);

  logic                   item_valid;
  sample_item_t           item;
  logic [SAMPLE_BITS-1:0] peak_level;
  logic [SPB_BITS-1:0]    position_in_bucket;
  logic [STEP_BITS-1:0]   step_phase;
  logic [INDEX_BITS-1:0]  bar_counter;

  logic                   advance;
  logic                   process;
  logic [SAMPLE_BITS-1:0] mag;
  logic [STEP_BITS-1:0]   phase_cur;
  logic [STEP_BITS-1:0]   phase_inc;
  logic [SAMPLE_BITS-1:0] peak_next;
  logic [SPB_BITS-1:0]    position_next;
  logic [STEP_BITS-1:0]   phase_next;
  logic                   done;

  assign advance   = !pend_valid || pend_take;
  assign smp_ready = !item_valid || advance;
  assign process   = item_valid && advance;

  always_comb begin
    // The most negative sample negates to itself, which read unsigned is full scale.
    mag           = item.sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-item.sample) : item.sample;
    phase_cur     = (step_phase >= cfg.step) ? '0 : step_phase;
    peak_next     = ((phase_cur == '0) && (mag > peak_level)) ? mag : peak_level;
    position_next = position_in_bucket + SPB_BITS'(1);
    phase_inc     = phase_cur + STEP_BITS'(1);
    phase_next    = (phase_inc >= cfg.step) ? '0 : phase_inc;
    done          = (position_next >= cfg.spb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (smp_ready) begin
      item_valid <= smp_valid;
    end
    if (smp_ready && smp_valid) begin
      item <= smp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_level         <= '0;
      position_in_bucket <= '0;
      step_phase         <= '0;
      bar_counter        <= '0;
    end else if (process) begin
      if (item.last_sample) begin
        peak_level         <= '0;
        position_in_bucket <= '0;
        step_phase         <= '0;
        bar_counter        <= '0;
      end else if (done) begin
        peak_level         <= '0;
        position_in_bucket <= '0;
        step_phase         <= '0;
        bar_counter        <= bar_counter + INDEX_BITS'(1);
      end else begin
        peak_level         <= peak_next;
        position_in_bucket <= position_next;
        step_phase         <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (advance) begin
      pend_valid <= process && done;
    end
    if (process && done) begin
      pend.bar_index <= bar_counter;
      pend.peak      <= peak_next;
    end
  end

endmodule

@@ rtl/wpb_bar_calc.sv @@
// ----------------------------------------------------------------------------
// Bar geometry stage
// Turns a finished bucket into position and height and holds the result
// transaction until it is taken.
// ----------------------------------------------------------------------------
module wpb_bar_calc
  import wpb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      pend_valid,
  output logic      pend_take,
  input  pend_bar_t pend,
  output logic      bar_valid,
  input  logic      bar_ready,
  output bar_item_t bar
);

  localparam int HPROD_BITS = VH_BITS + SAMPLE_BITS;
  localparam int HQ4_BITS   = HPROD_BITS + 4;
  localparam int D_BITS     = Q4_BITS + 2;

  logic [HPROD_BITS-1:0]     height_prod;
  logic [HQ4_BITS-1:0]       height_q4;
  logic [Q4_BITS-1:0]        height_raw;
  logic [Q4_BITS-1:0]        height;
  logic signed [D_BITS-1:0]  diff;
  logic signed [D_BITS-1:0]  top;
  logic [X_BITS-1:0]         x_pos;

  assign pend_take = !bar_valid || bar_ready;

  always_comb begin
    height_prod = HPROD_BITS'(cfg.view_height) * HPROD_BITS'(pend.peak);
    // Scale by 16 for the fraction bits, then divide by full scale.
    height_q4   = {height_prod, 4'b0000} >> (SAMPLE_BITS - 1);
    height_raw  = height_q4[Q4_BITS-1:0];
    height      = (height_raw < MIN_HEIGHT_Q4) ? MIN_HEIGHT_Q4 : height_raw;
    diff        = $signed({2'b00, cfg.view_height, 4'b0000}) - $signed({2'b00, height});
    top         = diff >>> 1;
    x_pos       = X_BITS'(pend.bar_index) *
                  X_BITS'({1'b0, cfg.bar_width} + {1'b0, cfg.bar_spacing});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_valid <= 1'b0;
    end else if (pend_take) begin
      bar_valid <= pend_valid;
    end
    if (pend_take && pend_valid) begin
      bar.bar_index     <= pend.bar_index;
      bar.bar_x         <= x_pos;
      bar.bar_y         <= top[Q4_BITS-1:0];
      bar.bar_out_width <= cfg.bar_width;
      bar.bar_height    <= height;
    end
  end

endmodule

@@ rtl/waveform_peak_bar_builder.sv @@
// Path: the sample that completes a bucket passes the input register, the pending register and the result register.
// Throughput: one sample per cycle; input register, bucket stage and result register all advance
// together, and only a stalled result register holds the input back.
// Reset (rst, synchronous): clears all valids, the peak, position, step phase and bar counter,
// and loads the configuration defaults; the block takes samples in the next cycle.
// ----------------------------------------------------------------------------
// Waveform peak bar builder
// Decimates a sample stream into one peak bar per complete bucket of samples.
// ----------------------------------------------------------------------------
module waveform_peak_bar_builder
  import wpb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      smp_valid,
  output logic                      smp_ready,
  input  sample_item_t              smp,
  output logic                      bar_valid,
  input  logic                      bar_ready,
  output bar_item_t                 bar
);

  cfg_t      cfg;
  logic      pend_valid;
  logic      pend_take;
  pend_bar_t pend;

  wpb_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wpb_bucket u_bucket (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .smp_valid  (smp_valid),
    .smp_ready  (smp_ready),
    .smp        (smp),
    .pend_valid (pend_valid),
    .pend_take  (pend_take),
    .pend       (pend)
  );

  wpb_bar_calc u_bar_calc (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pend_valid (pend_valid),
    .pend_take  (pend_take),
    .pend       (pend),
    .bar_valid  (bar_valid),
    .bar_ready  (bar_ready),
    .bar        (bar)
  );

endmodule
